// File: hdl/zbuffered_cube_point_renderer_top_defines.svh
// Assertion macros for the cube point renderer.
// Used by zbuffered_cube_point_renderer_top; expects a clock named clk and reset rst.
`ifndef ZBUFFERED_CUBE_POINT_RENDERER_TOP_DEFINES_SVH
`define ZBUFFERED_CUBE_POINT_RENDERER_TOP_DEFINES_SVH

// same-cycle implication
`define ZCPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zcpr same-cycle check failed");

// next-cycle implication
`define ZCPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zcpr next-cycle check failed");

`endif

// File: hdl/zcpr_pkg.sv
// Shared types, constants and helper functions for the cube point renderer.
// No dependencies; imported by zcpr_recip, zbuffered_cube_point_renderer_top and tb_top.
package zcpr_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 22;

  localparam int Q_W     = 16;
  localparam int V_W     = 24;
  localparam int P_W     = Q_W + V_W;
  localparam int DEPTH_W = 16;
  localparam int CELL_W  = 11;
  localparam int LVL_W   = 4;
  localparam int GLYPH_W = 7;
  localparam int DEN_W   = 24;
  localparam int RECIP_STEPS = 16;

  localparam logic signed [V_W-1:0] ONE_Q14     = 24'sd16384;
  localparam logic signed [V_W:0]   VIEW_OFFSET = 25'sd81920;
  localparam logic [DEN_W-1:0]      RECIP_INIT  = 24'd16384;
  localparam logic [DEPTH_W-1:0]    DEPTH_MAX   = 16'hFFFF;
  localparam int                    LIGHT8      = 302512;
  localparam logic [LVL_W-1:0]      LVL_MAX     = 4'd11;
  localparam logic [GLYPH_W-1:0]    GLYPH_BLANK = 7'd32;
  localparam logic [2:0]            FACE_LAST   = 3'd5;

  localparam logic [1:0] AX_Z = 2'b00;
  localparam logic [1:0] AX_P = 2'b01;
  localparam logic [1:0] AX_M = 2'b11;

  typedef enum logic [1:0] {
    CFG_SIN_A = 2'd0,
    CFG_COS_A = 2'd1,
    CFG_SIN_B = 2'd2,
    CFG_COS_B = 2'd3
  } zcpr_cfg_t;

  typedef enum logic [0:0] {
    CMD_CLEAR = 1'b0,
    CMD_PLOT  = 1'b1
  } zcpr_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_ROT0, S_ROT1, S_ROT2, S_ROT3, S_ROT4,
    S_RECIP, S_DIV, S_PROJ, S_POS, S_READ, S_CMP, S_DONE
  } zcpr_state_t;

  typedef logic [8:0][1:0] face_row_t;

  // order: normal xyz, u tangent xyz, v tangent xyz (entry 0 = normal x)
  function automatic face_row_t face_row(logic [2:0] f);
    face_row_t r;
    r = '0;
    case (f)
      3'd0: r = {AX_Z, AX_P, AX_Z, AX_Z, AX_Z, AX_P, AX_P, AX_Z, AX_Z};
      3'd1: r = {AX_Z, AX_P, AX_Z, AX_Z, AX_Z, AX_M, AX_M, AX_Z, AX_Z};
      3'd2: r = {AX_Z, AX_P, AX_Z, AX_M, AX_Z, AX_Z, AX_Z, AX_Z, AX_P};
      3'd3: r = {AX_Z, AX_P, AX_Z, AX_P, AX_Z, AX_Z, AX_Z, AX_Z, AX_M};
      3'd4: r = {AX_M, AX_Z, AX_Z, AX_Z, AX_Z, AX_P, AX_Z, AX_P, AX_Z};
      3'd5: r = {AX_P, AX_Z, AX_Z, AX_Z, AX_Z, AX_P, AX_Z, AX_M, AX_Z};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic signed [V_W-1:0] axis_term(logic [1:0] c,
                                                      logic signed [V_W-1:0] val);
    logic signed [V_W-1:0] r;
    case (c)
      AX_P:    r = val;
      AX_M:    r = -val;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q28 -> Q14, round half up
  function automatic logic signed [V_W-1:0] rnd14(logic signed [P_W:0] s);
    logic signed [P_W:0] t;
    t = s + (P_W+1)'(8192);
    return t[V_W+13:14];
  endfunction

  // divide by 2^30, truncate toward zero
  function automatic logic signed [15:0] trunc30(logic signed [45:0] p);
    logic signed [45:0] t;
    t = p[45] ? p + 46'sd1073741823 : p;
    return t[45:30];
  endfunction

  function automatic logic [GLYPH_W-1:0] ramp_glyph(logic [LVL_W-1:0] l);
    logic [GLYPH_W-1:0] g;
    case (l)
      4'd0:    g = 7'h2E;
      4'd1:    g = 7'h2C;
      4'd2:    g = 7'h2D;
      4'd3:    g = 7'h7E;
      4'd4:    g = 7'h3A;
      4'd5:    g = 7'h3B;
      4'd6:    g = 7'h3D;
      4'd7:    g = 7'h21;
      4'd8:    g = 7'h2A;
      4'd9:    g = 7'h23;
      4'd10:   g = 7'h24;
      4'd11:   g = 7'h40;
      default: g = GLYPH_BLANK;
    endcase
    return g;
  endfunction

endpackage

// File: hdl/zbuffered_cube_point_renderer_top.sv
// Top level of the depth-buffered cube point renderer: transform, projection, depth store.
// Depends on zcpr_pkg, zcpr_recip and zbuffered_cube_point_renderer_top_defines.svh.
//
//   channel | signals                                   | direction
//   in      | in_valid/in_ready, command face u/v       | sink
//   out     | out_valid/out_ready, cell/shade/glyph     | source
//   cfg     | cfg_we, cfg_index, cfg_data               | sink, write only
//
// A plot transaction runs from idle through two passes of the rotation states on a
// shared multiplier pair, the 16-step inverse-depth divider, projection and the depth
// read-compare-write, then loads the result; the divider is skipped when den_c <= 2^14.
// A clear transaction sweeps every entry of the depth memory, one entry a cycle.
// After reset the same sweep runs with in_ready low.
// A waiting result does not block the next transaction from being accepted.
`include "zbuffered_cube_point_renderer_top_defines.svh"

module zbuffered_cube_point_renderer_top import zcpr_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic [2:0]         face,
  input  logic signed [15:0] u_coord,
  input  logic signed [15:0] v_coord,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cell_written,
  output logic [CELL_W-1:0]  cell_index,
  output logic [LVL_W-1:0]   shade_level,
  output logic [GLYPH_W-1:0] glyph,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int AW    = $clog2(CELLS);
  localparam int X_MID = COLUMNS / 2;
  localparam int Y_MID = ROWS / 2 + 1;

  zcpr_state_t state, state_next;

  logic signed [Q_W-1:0] sin_a, cos_a, sin_b, cos_b;

  logic signed [V_W-1:0] vx, vy, vz, ptx, pty, ptz;
  logic signed [V_W-1:0] y1, z1, rx, ry, nsum;
  logic                  pass;
  logic                  clr_report;
  logic [AW-1:0]         clr_cnt;

  logic signed [Q_W-1:0] ma0, ma1;
  logic signed [V_W-1:0] mb0, mb1;
  logic signed [P_W-1:0] prod0, prod1;
  logic signed [P_W:0]   psub, padd;
  logic signed [V_W-1:0] rsub, radd;

  logic signed [V_W:0]   den_c;
  logic [DEPTH_W-1:0]    dval;
  logic [20:0]           m30, m15;
  logic signed [45:0]    projx, projy, shprod;
  logic signed [15:0]    xi, yi, lraw;
  logic                  in_bounds;
  logic [AW-1:0]         cell_addr, cell_addr_c;
  logic [LVL_W-1:0]      lvl;
  logic                  res_written;

  logic [DEPTH_W-1:0]    depth_mem [CELLS];
  logic [DEPTH_W-1:0]    rd_data;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr;
  logic [DEPTH_W-1:0]    mem_wdata;
  logic                  win;

  logic                  div_start, div_done;
  logic [15:0]           div_quot;
  logic                  out_load;
  logic                  in_fire;
  face_row_t             row;
  logic signed [V_W-1:0] u24, v24;

  assign in_fire = in_valid && in_ready;
  assign row     = face_row(face);
  assign u24     = V_W'(u_coord);
  assign v24     = V_W'(v_coord);

  zcpr_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .denom (den_c[DEN_W-1:0]),
    .done  (div_done),
    .quot  (div_quot)
  );

  // shared rotation multipliers
  always_comb begin
    ma0 = cos_a; mb0 = vy; ma1 = sin_a; mb1 = vz;
    case (state)
      S_ROT1: begin ma0 = sin_a; mb0 = vy; ma1 = cos_a; mb1 = vz; end
      S_ROT2: begin ma0 = cos_b; mb0 = vx; ma1 = sin_b; mb1 = y1; end
      S_ROT3: begin ma0 = sin_b; mb0 = vx; ma1 = cos_b; mb1 = y1; end
      default: ;
    endcase
  end

  assign psub  = (P_W+1)'(prod0) - (P_W+1)'(prod1);
  assign padd  = (P_W+1)'(prod0) + (P_W+1)'(prod1);
  assign rsub  = rnd14(psub);
  assign radd  = rnd14(padd);
  assign den_c = (V_W+1)'(z1) + VIEW_OFFSET;

  assign m30 = 21'(dval) * 21'd30;
  assign m15 = 21'(dval) * 21'd15;

  assign xi = trunc30(projx) + 16'(X_MID);
  assign yi = trunc30(projy) + 16'(Y_MID);
  assign in_bounds = (xi > 16'sd0) && (xi < 16'(COLUMNS)) &&
                     (yi > 16'sd0) && (yi < 16'(ROWS));
  assign cell_addr_c = AW'(xi) + AW'(yi) * AW'(COLUMNS);
  assign lraw = trunc30(shprod);
  assign win  = dval > rd_data;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (command == CMD_CLEAR)   state_next = S_CLEAR;
          else if (face > FACE_LAST)  state_next = S_DONE;
          else                        state_next = S_ROT0;
        end
      end
      S_CLEAR: begin
        if (clr_cnt == AW'(CELLS - 1)) state_next = clr_report ? S_DONE : S_IDLE;
      end
      S_ROT0: state_next = S_ROT1;
      S_ROT1: state_next = S_ROT2;
      S_ROT2: state_next = S_ROT3;
      S_ROT3: state_next = S_ROT4;
      S_ROT4: state_next = pass ? S_RECIP : S_ROT0;
      S_RECIP: begin
        if (den_c <= 0)                    state_next = S_DONE;
        else if (den_c <= 25'sd16384)      state_next = S_PROJ;
        else                               state_next = S_DIV;
      end
      S_DIV:  if (div_done) state_next = S_PROJ;
      S_PROJ: state_next = S_POS;
      S_POS:  state_next = in_bounds ? S_READ : S_DONE;
      S_READ: state_next = S_CMP;
      S_CMP:  state_next = S_DONE;
      S_DONE: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = dval;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt;
        mem_wdata = '0;
      end
      S_RECIP: div_start = (den_c > 25'sd16384);
      S_READ:  mem_re = 1'b1;
      S_CMP:   mem_we = win;
      S_DONE:  out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) depth_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= depth_mem[cell_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      clr_report <= 1'b0;
      out_valid  <= 1'b0;
      pass       <= 1'b0;
      sin_a      <= '0;
      cos_a      <= ONE_Q14[Q_W-1:0];
      sin_b      <= '0;
      cos_b      <= ONE_Q14[Q_W-1:0];
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SIN_A: sin_a <= cfg_data;
          CFG_COS_A: cos_a <= cfg_data;
          CFG_SIN_B: sin_b <= cfg_data;
          CFG_COS_B: cos_b <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (in_fire && command == CMD_CLEAR) begin
        clr_cnt    <= '0;
        clr_report <= 1'b1;
      end
      if (in_fire) pass <= 1'b0;
      else if (state == S_ROT4) pass <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod0 <= ma0 * mb0;
    prod1 <= ma1 * mb1;
    if (in_fire) begin
      res_written <= 1'b0;
      vx  <= axis_term(row[0], ONE_Q14);
      vy  <= axis_term(row[1], ONE_Q14);
      vz  <= axis_term(row[2], ONE_Q14);
      ptx <= (axis_term(row[0], ONE_Q14) + axis_term(row[3], u24)
              + axis_term(row[6], v24)) <<< 1;
      pty <= (axis_term(row[1], ONE_Q14) + axis_term(row[4], u24)
              + axis_term(row[7], v24)) <<< 1;
      ptz <= (axis_term(row[2], ONE_Q14) + axis_term(row[5], u24)
              + axis_term(row[8], v24)) <<< 1;
    end
    case (state)
      S_ROT1: y1 <= rsub;
      S_ROT2: z1 <= radd;
      S_ROT3: rx <= rsub;
      S_ROT4: begin
        ry <= radd;
        if (!pass) begin
          nsum <= rx + radd + z1;
          vx   <= ptx;
          vy   <= pty;
          vz   <= ptz;
        end
      end
      S_RECIP: dval <= DEPTH_MAX;
      S_DIV:   if (div_done) dval <= div_quot;
      S_PROJ: begin
        projx  <= $signed({1'b0, m30}) * rx;
        projy  <= $signed({1'b0, m15}) * ry;
        shprod <= nsum * $signed(22'(LIGHT8));
      end
      S_POS: begin
        cell_addr <= cell_addr_c;
        if (lraw < 16'sd0)                 lvl <= '0;
        else if (lraw > 16'(LVL_MAX))      lvl <= LVL_MAX;
        else                               lvl <= lraw[LVL_W-1:0];
      end
      S_CMP: res_written <= win;
      default: ;
    endcase
    if (out_load) begin
      cell_written <= res_written;
      cell_index   <= res_written ? CELL_W'(cell_addr) : '0;
      shade_level  <= res_written ? lvl : '0;
      glyph        <= res_written ? ramp_glyph(lvl) : GLYPH_BLANK;
    end
  end

  `ZCPR_ASSERT_NOW(a_busy_no_accept, state != S_IDLE, !in_ready)
  `ZCPR_ASSERT_NOW(a_write_source, mem_we, (state == S_CLEAR) || (state == S_CMP))
  `ZCPR_ASSERT_NEXT(a_cmp_to_done, state == S_CMP, state == S_DONE)
  `ZCPR_ASSERT_NOW(a_shade_range, out_valid && cell_written, shade_level <= LVL_MAX)

endmodule

// File: hdl/zcpr_recip.sv
// Restoring divider producing floor(2^30 / denom) for denom above 2^14.
// Depends on zcpr_pkg; one quotient bit per cycle.
module zcpr_recip import zcpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DEN_W-1:0] denom,
  output logic             done,
  output logic [15:0]      quot
);

  localparam int CNT_W = $clog2(RECIP_STEPS);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   rem2;

  assign rem2 = {rem, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(RECIP_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= RECIP_INIT;
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      if (rem2 >= {1'b0, den}) begin
        rem  <= DEN_W'(rem2 - {1'b0, den});
        quot <= {quot[14:0], 1'b1};
      end else begin
        rem  <= rem2[DEN_W-1:0];
        quot <= {quot[14:0], 1'b0};
      end
    end
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench for the depth-buffered cube point renderer: directed cases, then random bursts.
// Depends on zcpr_pkg and zbuffered_cube_point_renderer_top; predicts results in-line.
module tb_top import zcpr_pkg::*; ();

  localparam int COLS = 80;
  localparam int NROWS = 22;
  localparam int NCELLS = COLS * NROWS;
  localparam int N_RANDOM = 920;
  localparam int SETTLE = 2000;

  typedef struct packed {
    logic        command;
    logic [2:0]  face;
    logic [15:0] u;
    logic [15:0] v;
  } sample_t;

  typedef struct packed {
    logic        written;
    logic [10:0] idx;
    logic [3:0]  level;
    logic [6:0]  glyph;
  } pixel_t;

  typedef struct {
    sample_t s;
    logic    known;
    pixel_t  p;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = 1'b0;
  logic [2:0] face = '0;
  logic signed [15:0] u_coord = '0;
  logic signed [15:0] v_coord = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic cell_written;
  logic [10:0] cell_index;
  logic [3:0] shade_level;
  logic [6:0] glyph;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  zbuffered_cube_point_renderer_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  logic [15:0] zbuf [NCELLS];
  longint sa, ca, sb, cb;
  pixel_t pending_pixels[$];
  int errors = 0;
  bit hold_off = 0;
  bit stim_done = 0;

  function automatic longint to_q14(longint x);
    longint y, q;
    y = x + 8192;
    q = y / 16384;
    if (y % 16384 < 0) q -= 1;
    return q;
  endfunction

  task automatic rotate(input longint x, input longint y, input longint z,
                        output longint xo, output longint yo, output longint zo);
    longint y1;
    y1 = to_q14(ca * y - sa * z);
    zo = to_q14(sa * y + ca * z);
    xo = to_q14(cb * x - sb * y1);
    yo = to_q14(sb * x + cb * y1);
  endtask

  function automatic int axis(int f, int k);
    int tab[6][9] = '{
      '{0, 0, 1, 1, 0, 0, 0, 1, 0}, '{0, 0, -1, -1, 0, 0, 0, 1, 0},
      '{1, 0, 0, 0, 0, -1, 0, 1, 0}, '{-1, 0, 0, 0, 0, 1, 0, 1, 0},
      '{0, 1, 0, 1, 0, 0, 0, 0, -1}, '{0, -1, 0, 1, 0, 0, 0, 0, 1}};
    return tab[f][k];
  endfunction

  task automatic predict_pixel(input sample_t s, output pixel_t p);
    byte shades[12] = '{".", ",", "-", "~", ":", ";", "=", "!", "*", "#", "$", "@"};
    longint pt[3], x2, y2, z2, nx, ny, nz, den, d, xi, yi, o, lvl, uu, vv;
    int f;
    p = '{1'b0, 11'd0, 4'd0, 7'd32};
    if (s.command == CMD_CLEAR) begin
      foreach (zbuf[i]) zbuf[i] = '0;
      return;
    end
    if (s.face > FACE_LAST) return;
    f = s.face;
    uu = longint'($signed(s.u));
    vv = longint'($signed(s.v));
    for (int i = 0; i < 3; i++)
      pt[i] = 2 * (axis(f, i) * 16384 + uu * axis(f, 3 + i) + vv * axis(f, 6 + i));
    rotate(pt[0], pt[1], pt[2], x2, y2, z2);
    den = z2 + 5 * 16384;
    if (den <= 0) return;
    d = (longint'(1) << 30) / den;
    if (d > 65535) d = 65535;
    xi = COLS / 2 + (30 * d * x2) / (longint'(1) << 30);
    yi = NROWS / 2 + 1 + (15 * d * y2) / (longint'(1) << 30);
    if (!(yi > 0 && yi < NROWS && xi > 0 && xi < COLS)) return;
    o = xi + COLS * yi;
    if (o >= NCELLS || d <= zbuf[o]) return;
    zbuf[o] = d[15:0];
    rotate(axis(f, 0) * 16384, axis(f, 1) * 16384, axis(f, 2) * 16384, nx, ny, nz);
    lvl = (8 * 37814 * (nx + ny + nz)) / (longint'(1) << 30);
    if (lvl < 0) lvl = 0;
    if (lvl > 11) lvl = 11;
    p = '{1'b1, o[10:0], lvl[3:0], shades[lvl][6:0]};
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  task automatic write_reg(input zcpr_cfg_t idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SIN_A: sa = longint'($signed(val));
      CFG_COS_A: ca = longint'($signed(val));
      CFG_SIN_B: sb = longint'($signed(val));
      default:   cb = longint'($signed(val));
    endcase
  endtask

  task automatic set_angles(input logic [15:0] s_a, input logic [15:0] c_a,
                            input logic [15:0] s_b, input logic [15:0] c_b);
    write_reg(CFG_SIN_A, s_a);
    write_reg(CFG_COS_A, c_a);
    write_reg(CFG_SIN_B, s_b);
    write_reg(CFG_COS_B, c_b);
  endtask

  // drop valid, then wait for every result
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // offer one transaction; valid is held until accepted
  task automatic send(input sample_t s, input logic known, input pixel_t want);
    pixel_t p;
    predict_pixel(s, p);
    if (known && p !== want) report("table row", 32'(p), 32'(want));
    in_valid <= 1'b1;
    command <= s.command;
    face <= s.face;
    u_coord <= s.u;
    v_coord <= s.v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_pixels.push_back(p);
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 16'(-16384);
      1:       return 16'(16384);
      2:       return 16'($urandom());
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    case ($urandom_range(0, 5))
      0:       return 16'($urandom());
      1:       return 16'(16384);
      2:       return 16'(-16384);
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        report("unexpected result", 32'(cell_index), 0);
      end else begin
        pixel_t w;
        w = pending_pixels.pop_front();
        if (cell_written !== w.written)
          report("cell_written", 32'(cell_written), 32'(w.written));
        if (cell_index !== w.idx) report("cell_index", 32'(cell_index), 32'(w.idx));
        if (shade_level !== w.level) report("shade_level", 32'(shade_level), 32'(w.level));
        if (glyph !== w.glyph) report("glyph", 32'(glyph), 32'(w.glyph));
      end
    end
  end

  // receiver stall pattern, with one long hold-off on request
  initial begin
    int k;
    k = 0;
    forever begin
      @(posedge clk);
      k++;
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end else if (k % 512 < 128) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    #400ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    sample_t s;
    int burst;
    int gap;
    sa = 0; ca = 16384; sb = 0; cb = 16384;
    foreach (zbuf[i]) zbuf[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{'{CMD_PLOT, 3'd0, 16'd0, 16'd0}, 1'b1, '{1'b1, 11'd1000, 4'd4, 7'h3A}});
    rows.push_back('{'{CMD_PLOT, 3'd0, 16'd0, 16'd0}, 1'b1, '{1'b0, 11'd0, 4'd0, 7'd32}});
    rows.push_back('{'{CMD_CLEAR, 3'd7, 16'hFFFF, 16'h8000}, 1'b1, '{1'b0, 11'd0, 4'd0, 7'd32}});
    rows.push_back('{'{CMD_PLOT, 3'd6, 16'd0, 16'd0}, 1'b1, '{1'b0, 11'd0, 4'd0, 7'd32}});
    rows.push_back('{'{CMD_PLOT, 3'd7, 16'h4000, 16'h4000}, 1'b1, '{1'b0, 11'd0, 4'd0, 7'd32}});
    for (int f = 0; f < 6; f++) begin
      rows.push_back('{'{CMD_PLOT, 3'(f), 16'h4000, 16'hC000}, 1'b0, '0});
      rows.push_back('{'{CMD_PLOT, 3'(f), 16'hC000, 16'h4000}, 1'b0, '0});
    end
    rows.push_back('{'{CMD_PLOT, 3'd1, 16'h7FFF, 16'h8000}, 1'b0, '0});
    rows.push_back('{'{CMD_PLOT, 3'd2, 16'h8000, 16'h7FFF}, 1'b0, '0});
    rows.push_back('{'{CMD_PLOT, 3'd1, 16'd0, 16'd0}, 1'b0, '0});
    foreach (rows[i]) send(rows[i].s, rows[i].known, rows[i].p);
    drain();

    // a far point, a point behind the viewer, both with big coordinates
    set_angles(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    send('{CMD_PLOT, 3'd0, 16'h8000, 16'h8000}, 1'b0, '0);
    send('{CMD_PLOT, 3'd4, 16'h7FFF, 16'h7FFF}, 1'b0, '0);
    drain();
    set_angles(16'd16384, 16'd0, 16'(-16384), 16'd0);
    send('{CMD_PLOT, 3'd4, 16'd0, 16'd0}, 1'b0, '0);
    send('{CMD_PLOT, 3'd5, 16'd100, 16'd100}, 1'b0, '0);
    drain();

    hold_off = 1;
    for (int n = 0; n < N_RANDOM;) begin
      if (n % 230 == 0 && n != 0) begin
        drain();
        set_angles(rand_trig(), rand_trig(), rand_trig(), rand_trig());
      end
      burst = $urandom_range(1, 12);
      for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
        s.command = ($urandom_range(0, 40) != 0) ? CMD_PLOT : CMD_CLEAR;
        s.face = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                               : 3'($urandom_range(0, 5));
        s.u = rand_coord();
        s.v = rand_coord();
        send(s, 1'b0, '0);
      end
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
